// ===== sv/dlte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlte_pkg;

  // Fixed field widths
  localparam int RADIUS_W       = 16;
  localparam int K_W            = 8;
  localparam int IN_DATA_W      = 8;
  localparam int COORD_BITS_DEF = 9;

  // Stored coordinates never leave a disc of squared radius below 2^16
  localparam int MAG_W  = 8;
  // Odd magnitude |2k+1| and its candidate successor
  localparam int ODD_W  = 9;
  // Squared norms, including one step beyond the disc
  localparam int NORM_W = 17;

  // Which point of the current column is next
  typedef enum logic [2:0] {
    PH_AXIS_POS = 3'd0,  // (0, y)
    PH_AXIS_NEG = 3'd1,  // (0, -y)
    PH_PP       = 3'd2,  // (x, y)
    PH_NP       = 3'd3,  // (-x, y)
    PH_PN       = 3'd4,  // (x, -y)
    PH_NN       = 3'd5   // (-x, -y)
  } phase_e;

  // Walk position, always settled on a deliverable triplet unless finished or start
  typedef struct packed {
    logic [MAG_W-1:0]  row_y;
    logic [MAG_W-1:0]  col_x;
    phase_e            point_phase;
    logic [ODD_W-1:0]  odd_mag;       // |2k+1|
    logic [NORM_W-1:0] odd_sq;        // (2k+1)^2
    logic              k_descending;
    logic [NORM_W-1:0] cur_norm_sq;   // x^2 + y^2
    logic [NORM_W-1:0] row_sq;        // y^2
    logic              finished;
    logic              start;         // rewound, first point not yet chosen
  } walk_t;

  // One delivered triplet in sign/magnitude form
  typedef struct packed {
    logic              valid_res;
    logic [MAG_W-1:0]  col_x;
    logic [MAG_W-1:0]  row_y;
    logic              neg_p;
    logic              neg_q;
    logic [K_W-1:0]    k_index;
    logic              last;
  } emit_t;

endpackage

`default_nettype wire

// ===== sv/disc_lattice_triplet_enumerator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Disc lattice triplet enumerator. Every input beat requests the next triplet
// (p, q, k) of a fixed walk over the lattice points of the disc
// p*p + q*q <= radius_sq: rows y = 0, 1, 2, ..., axis points first, then for
// x = 1, 2, ... the points (x,y), (-x,y), (x,-y), (-x,-y); row 0 gives each point
// once and the origin gives nothing. For each point k climbs from 0 while
// (2k+1)^2 fits under the norm, then falls from -1 under the same test.
// tlast flags the final triplet; once the walk is done every request answers
// with tuser = 0 and zero data until a beat with restart set rewinds it (the
// first request after reset starts from the beginning as well). Throughput is
// one triplet per clock unless the sink stalls, each shown in the cycle after
// its request: the walk position sits in one register and a single pass of add
// and compare logic picks the next position, feeding a one-deep output register
// that frees up as soon as the sink takes its beat. Write radius_sq only with no
// request in flight; a shrunk radius is applied at the write, skipping a point
// that falls outside. s_axis_tready drops while a configuration beat is offered.
module disc_lattice_triplet_enumerator #(
  parameter int COORD_BITS = dlte_pkg::COORD_BITS_DEF,
  localparam int OutDataW  = ((2 * COORD_BITS + dlte_pkg::K_W + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write: radius_sq
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [dlte_pkg::RADIUS_W-1:0]  cfg_wdata_i,
  // request stream
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [dlte_pkg::IN_DATA_W-1:0] s_axis_tdata_i,   // [0] restart
  // triplet stream
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output      logic [OutDataW-1:0]            m_axis_tdata_o,   // p_coord, q_coord, k_index
  output      logic [0:0]                     m_axis_tuser_o,   // valid_res
  output      logic                           m_axis_tlast_o
);
  import dlte_pkg::*;

  // Reset position: all zero with the start mark (last struct member) set
  localparam walk_t WalkStart = walk_t'({{($bits(walk_t)-1){1'b0}}, 1'b1});

  walk_t                   walk_q, walk_d;
  walk_t                   adv;
  walk_t                   resettle;
  emit_t                   emit;
  logic [RADIUS_W-1:0]     radius_q, radius_d;
  logic                    in_fire;
  logic                    cfg_fire;
  logic                    restart;
  logic                    out_valid_q, out_valid_d;
  logic [OutDataW-1:0]     out_data_q;
  logic                    out_user_q;
  logic                    out_last_q;
  logic [COORD_BITS-1:0]   p_mag, q_mag;
  logic [COORD_BITS-1:0]   p_val, q_val;

  assign restart = s_axis_tdata_i[0];

  // Config beats are always taken; hold off requests while one is offered
  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = (!out_valid_q || m_axis_tready_i) && !cfg_valid_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  dlte_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cur_i        (walk_q),
    .restart_i    (restart),
    .radius_i     (radius_q),
    .cfg_radius_i (cfg_wdata_i),
    .adv_o        (adv),
    .emit_o       (emit),
    .resettle_o   (resettle)
  );

  // Advance the walk on a request, re-check it against a new radius on a write
  always_comb begin
    walk_d   = walk_q;
    radius_d = radius_q;
    if (cfg_fire) begin
      walk_d   = resettle;
      radius_d = cfg_wdata_i;
    end else if (in_fire) begin
      walk_d = adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= WalkStart;
      radius_q <= '0;
    end else begin
      walk_q   <= walk_d;
      radius_q <= radius_d;
    end
  end

  // Turn sign/magnitude into two's complement coordinates
  assign p_mag = COORD_BITS'(emit.col_x);
  assign q_mag = COORD_BITS'(emit.row_y);
  assign p_val = emit.neg_p ? -p_mag : p_mag;
  assign q_val = emit.neg_q ? -q_mag : q_mag;

  // Output register: load on a request, drop valid once the sink takes the beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= OutDataW'({emit.k_index, q_val, p_val});
      out_user_q <= emit.valid_res;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_user_q;
  assign m_axis_tlast_o    = out_last_q;

`ifndef SYNTHESIS
  // Every accepted request shows up at the output on the next clock
  a_req_to_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid_o)
    else $error("request did not produce an output beat");

  // An exhausted walk answers with an empty beat unless rewound
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !restart && walk_q.finished && !walk_q.start |=> !m_axis_tuser_o[0])
    else $error("triplet delivered after the walk finished");

  // A settled position lies inside the disc
  a_in_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walk_q.finished && !walk_q.start |-> walk_q.cur_norm_sq <= NORM_W'(radius_q))
    else $error("walk position outside the disc");

  // A settled k fits under the point's norm
  a_k_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walk_q.finished && !walk_q.start |-> walk_q.odd_sq <= walk_q.cur_norm_sq)
    else $error("k out of range for the current point");

  // Requests are never taken in the same cycle as a config write
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !s_axis_tready_o)
    else $error("request accepted alongside a config write");
`endif

endmodule

`default_nettype wire

// ===== sv/dlte_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dlte_step #(
  parameter int COORD_BITS = dlte_pkg::COORD_BITS_DEF
) (
  input  wire dlte_pkg::walk_t              cur_i,
  input  wire logic                         restart_i,
  input  wire logic [dlte_pkg::RADIUS_W-1:0] radius_i,
  input  wire logic [dlte_pkg::RADIUS_W-1:0] cfg_radius_i,
  output dlte_pkg::walk_t                   adv_o,
  output dlte_pkg::emit_t                   emit_o,
  output dlte_pkg::walk_t                   resettle_o
);
  import dlte_pkg::*;

  localparam int CoordLimit = (1 << (COORD_BITS - 1)) - 1;
  localparam int CandTop    = (1 << (MAG_W + 1)) - 1;
  localparam logic [MAG_W:0] CandMax =
    (CoordLimit > CandTop) ? {(MAG_W+1){1'b1}} : (MAG_W+1)'(CoordLimit);

  walk_t             eff;
  walk_t             nxt;
  walk_t             rs;
  logic [ODD_W-1:0]  odd_next;
  logic [NORM_W-1:0] sq_next;
  logic [MAG_W:0]    col_cand;
  logic [NORM_W-1:0] col_norm;
  logic              col_ok;
  logic [MAG_W:0]    row_cand;
  logic [NORM_W-1:0] row_norm;
  logic              row_ok;
  logic [MAG_W:0]    rs_row_cand;
  logic [NORM_W-1:0] rs_row_norm;
  logic              move_col;
  phase_e            col_phase;
  logic [K_W-1:0]    k_half;

  // Effective position: a rewind lands on (1,0) when the disc holds it
  always_comb begin
    eff = cur_i;
    if (cur_i.start || restart_i) begin
      eff.row_y        = '0;
      eff.col_x        = MAG_W'(1);
      eff.point_phase  = PH_PN;
      eff.odd_mag      = ODD_W'(1);
      eff.odd_sq       = NORM_W'(1);
      eff.k_descending = 1'b0;
      eff.cur_norm_sq  = NORM_W'(1);
      eff.row_sq       = '0;
      eff.finished     = (radius_i == '0);
      eff.start        = 1'b0;
    end
  end

  assign odd_next = eff.odd_mag + ODD_W'(2);
  assign sq_next  = eff.odd_sq + NORM_W'({eff.odd_mag, 2'b00}) + NORM_W'(4);

  assign col_cand = {1'b0, eff.col_x} + (MAG_W+1)'(1);
  assign col_norm = eff.cur_norm_sq + NORM_W'({eff.col_x, 1'b1});
  assign col_ok   = (col_cand <= CandMax) && (col_norm <= NORM_W'(radius_i));

  assign row_cand = {1'b0, eff.row_y} + (MAG_W+1)'(1);
  assign row_norm = eff.row_sq + NORM_W'({eff.row_y, 1'b1});
  assign row_ok   = (row_cand <= CandMax) && (row_norm <= NORM_W'(radius_i));

  // Advance past the delivered triplet and settle on the next one
  always_comb begin
    nxt       = eff;
    move_col  = 1'b0;
    col_phase = PH_PP;
    if (!eff.finished) begin
      if (sq_next <= eff.cur_norm_sq) begin
        nxt.odd_mag = odd_next;
        nxt.odd_sq  = sq_next;
      end else if (!eff.k_descending) begin
        nxt.k_descending = 1'b1;
        nxt.odd_mag      = ODD_W'(1);
        nxt.odd_sq       = NORM_W'(1);
      end else begin
        nxt.k_descending = 1'b0;
        nxt.odd_mag      = ODD_W'(1);
        nxt.odd_sq       = NORM_W'(1);
        unique case (eff.point_phase)
          PH_AXIS_POS: begin
            if (eff.row_y != '0) begin
              nxt.point_phase = PH_AXIS_NEG;
            end else begin
              move_col  = 1'b1;
              col_phase = PH_PN;
            end
          end
          PH_AXIS_NEG: begin
            move_col  = 1'b1;
            col_phase = PH_PP;
          end
          PH_PP: nxt.point_phase = PH_NP;
          PH_NP: nxt.point_phase = PH_PN;
          PH_PN: nxt.point_phase = PH_NN;
          PH_NN: begin
            move_col  = 1'b1;
            col_phase = (eff.row_y != '0) ? PH_PP : PH_PN;
          end
          default: nxt.finished = 1'b1;
        endcase
        if (move_col) begin
          if (col_ok) begin
            nxt.col_x       = col_cand[MAG_W-1:0];
            nxt.cur_norm_sq = col_norm;
            nxt.point_phase = col_phase;
          end else begin
            nxt.row_y       = row_cand[MAG_W-1:0];
            nxt.col_x       = '0;
            nxt.point_phase = PH_AXIS_POS;
            nxt.cur_norm_sq = row_norm;
            nxt.row_sq      = row_norm;
            nxt.finished    = !row_ok;
          end
        end
      end
    end
  end

  assign adv_o = nxt;

  // Delivered triplet; descending k is -(half+1), i.e. the complement of half
  assign k_half = eff.odd_mag[ODD_W-1:1];

  always_comb begin
    emit_o = '0;
    if (!eff.finished) begin
      emit_o.valid_res = 1'b1;
      emit_o.col_x     = eff.col_x;
      emit_o.row_y     = eff.row_y;
      emit_o.neg_p     = (eff.point_phase == PH_NP) || (eff.point_phase == PH_NN);
      emit_o.neg_q     = (eff.point_phase == PH_AXIS_NEG) || (eff.point_phase == PH_PN) ||
                         (eff.point_phase == PH_NN);
      emit_o.k_index   = eff.k_descending ? ~k_half : k_half;
      emit_o.last      = nxt.finished;
    end
  end

  // New radius: a point now outside the disc moves on to the next row start, or ends the walk if on the axis
  assign rs_row_cand = {1'b0, cur_i.row_y} + (MAG_W+1)'(1);
  assign rs_row_norm = cur_i.row_sq + NORM_W'({cur_i.row_y, 1'b1});

  always_comb begin
    rs = cur_i;
    if (!cur_i.start && !cur_i.finished &&
        (cur_i.cur_norm_sq > NORM_W'(cfg_radius_i))) begin
      rs.k_descending = 1'b0;
      rs.odd_mag      = ODD_W'(1);
      rs.odd_sq       = NORM_W'(1);
      if (cur_i.col_x == '0) begin
        rs.finished = 1'b1;
      end else begin
        rs.row_y       = rs_row_cand[MAG_W-1:0];
        rs.col_x       = '0;
        rs.point_phase = PH_AXIS_POS;
        rs.cur_norm_sq = rs_row_norm;
        rs.row_sq      = rs_row_norm;
        rs.finished    = !((rs_row_cand <= CandMax) &&
                           (rs_row_norm <= NORM_W'(cfg_radius_i)));
      end
    end
  end

  assign resettle_o = rs;

endmodule

`default_nettype wire
